/* rtl/core/nslr_pkg.sv */
// Shared types and constants for the negative semivariance block.
package nslr_pkg;

  localparam int MaxSeriesLenDef = 65536;
  localparam int LogFrac = 24;
  localparam logic [31:0] Ln2Q32 = 32'hB17217F8;

  typedef struct packed {
    logic signed [31:0] price;
    logic               price_is_nan;
    logic               last_of_series;
  } in_req_t;

  typedef struct packed {
    logic [31:0] semivariance;
    logic        defined;
    logic [15:0] negative_count;
  } out_res_t;

  typedef struct packed {
    logic [30:0] price;
    logic        ok;
    logic        last;
  } q_item_t;

  typedef struct packed {
    logic    vld;
    q_item_t item;
  } q_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOG,
    ST_PAIR,
    ST_MUL,
    ST_RND,
    ST_SQ,
    ST_ACC,
    ST_UPD,
    ST_DIV,
    ST_OUT
  } back_state_e;

endpackage

/* rtl/core/negative_semivariance_log_return.sv */
// Top level of the downside semivariance of log returns block.
// Input channel: in_valid_i / in_stall_o carries one price request per
// accepted cycle (price Q15.16, NaN flag, end-of-series flag). A front
// stage classifies each sample and places it in a two-entry queue; the
// back end drains the queue one sample at a time.
// Per sample the back end skips the log unit for an invalid price; for a
// valid one the log unit runs 24 squaring steps on one 31x31 multiplier, and
// a counted negative return adds the ln2 scale, rounding, squaring and
// accumulation steps. On an end-of-series sample with negative returns the
// 32-step divider runs before the result is registered on out_valid_o /
// out_res_o; one result leaves per series.
// Reset clears the queue, the accumulator, the counter and the result
// valid flag. While the receiver stalls the result holds, the back end waits
// only at the next series end, and the front keeps taking requests until
// the queue is full.
module negative_semivariance_log_return #(
  parameter int MaxSeriesLen = nslr_pkg::MaxSeriesLenDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  nslr_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output nslr_pkg::out_res_t out_res_o
);

  localparam int NegCapInt = (MaxSeriesLen - 1 < 65535) ? MaxSeriesLen - 1 : 65535;
  localparam logic [15:0] NegCap = 16'(NegCapInt);

  nslr_pkg::q_stat_t q_stat;
  logic              q_pop;

  nslr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_req_i  (in_req_i),
    .q_stat_o  (q_stat),
    .q_pop_i   (q_pop)
  );

  nslr_back #(
    .NegCap(NegCap)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_stat_i   (q_stat),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o)
  );

endmodule

/* rtl/core/nslr_front.sv */
// Front end: accepts price requests, classifies them and queues them.
module nslr_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  nslr_pkg::in_req_t in_req_i,
  output nslr_pkg::q_stat_t q_stat_o,
  input  logic             q_pop_i
);

  nslr_pkg::q_item_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  nslr_pkg::q_item_t item;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push = in_valid_i && !in_stall_o;

  always_comb begin
    item.price = in_req_i.price[30:0];
    item.ok = !in_req_i.price_is_nan && (in_req_i.price != 32'sd0) && !in_req_i.price[31];
    item.last = in_req_i.last_of_series;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

  assign q_stat_o.vld = (cnt_q != 2'd0);
  assign q_stat_o.item = mem_q[rd_ptr_q];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue count out of range");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> cnt_q != 2'd0) else $error("pop from empty queue");
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !q_pop_i) |=> cnt_q == 2'd2) else $error("full queue lost entry");

endmodule

/* rtl/core/nslr_div.sv */
// Iterative saturating divider: 32-bit quotient of a 64-bit numerator.
module nslr_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [25:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o
);

  logic        busy_q, done_q, sat_q;
  logic [4:0]  step_q;
  logic [25:0] rem_q, den_q;
  logic [31:0] low_q;
  logic [26:0] trial;
  logic        qbit;

  assign trial = {rem_q, low_q[31]};
  assign qbit = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 5'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 5'd0;
      end else if (busy_q) begin
        step_q <= step_q + 5'd1;
        if (sat_q || step_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sat_q <= (num_i[63:32] >= {6'd0, den_i});
      rem_q <= num_i[57:32];
      low_q <= num_i[31:0];
      den_q <= den_i;
    end else if (busy_q && !sat_q) begin
      rem_q <= qbit ? 26'(trial - {1'b0, den_q}) : trial[25:0];
      low_q <= {low_q[30:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quo_o = sat_q ? 32'hFFFFFFFF : low_q;

endmodule

/* rtl/core/nslr_back.sv */
// Back end: log approximation, squared-return accumulation and series result.
module nslr_back #(
  parameter logic [15:0] NegCap = 16'd65535
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nslr_pkg::q_stat_t q_stat_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output nslr_pkg::out_res_t out_res_o
);

  nslr_pkg::back_state_e state_q, state_d;
  nslr_pkg::q_item_t cur_q;
  logic [4:0]  e_q, e_in;
  logic [30:0] m_q, m_in, m_nx;
  logic [23:0] frac_q;
  logic [4:0]  iter_q;
  logic [61:0] sqr;
  logic [31:0] msq;
  logic [31:0] cur_log, prev_log_q, d;
  logic [30:0] prev_p_q;
  logic        prev_ok_q;
  logic [63:0] prod_q, sq_q, sum_q, prod_rnd, sq_rnd;
  logic [31:0] r_q;
  logic [15:0] cnt_q, res_cnt_q;
  logic        hit, div_start, div_done, out_load;
  logic [31:0] div_quo;
  logic        out_vld_q;
  nslr_pkg::out_res_t out_q;

  always_comb begin
    e_in = 5'd0;
    for (int i = 0; i < 31; i++) begin
      if (q_stat_i.item.price[i]) e_in = 5'(i);
    end
    m_in = q_stat_i.item.price << (5'd30 - e_in);
  end

  assign sqr = 62'(m_q) * 62'(m_q);
  assign msq = sqr[61:30];
  assign m_nx = msq[31] ? msq[31:1] : msq[30:0];
  assign cur_log = {3'd0, e_q, frac_q};
  assign d = prev_log_q - cur_log;
  assign hit = cur_q.ok && prev_ok_q && (cur_q.price < prev_p_q) && (cnt_q < NegCap);
  assign prod_rnd = prod_q + 64'h80000000;
  assign sq_rnd = sq_q + 64'h8000;
  assign out_load = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nslr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      nslr_pkg::ST_IDLE: begin
        if (q_stat_i.vld) begin
          q_pop_o = 1'b1;
          state_d = q_stat_i.item.ok ? nslr_pkg::ST_LOG : nslr_pkg::ST_PAIR;
        end
      end
      nslr_pkg::ST_LOG: begin
        if (iter_q == 5'(nslr_pkg::LogFrac - 1)) state_d = nslr_pkg::ST_PAIR;
      end
      nslr_pkg::ST_PAIR: state_d = hit ? nslr_pkg::ST_MUL : nslr_pkg::ST_UPD;
      nslr_pkg::ST_MUL: state_d = nslr_pkg::ST_RND;
      nslr_pkg::ST_RND: state_d = nslr_pkg::ST_SQ;
      nslr_pkg::ST_SQ: state_d = nslr_pkg::ST_ACC;
      nslr_pkg::ST_ACC: state_d = nslr_pkg::ST_UPD;
      nslr_pkg::ST_UPD: begin
        if (!cur_q.last) begin
          state_d = nslr_pkg::ST_IDLE;
        end else if (cnt_q == 16'd0) begin
          state_d = nslr_pkg::ST_OUT;
        end else begin
          div_start = 1'b1;
          state_d = nslr_pkg::ST_DIV;
        end
      end
      nslr_pkg::ST_DIV: begin
        if (div_done) state_d = nslr_pkg::ST_OUT;
      end
      nslr_pkg::ST_OUT: begin
        if (out_load) state_d = nslr_pkg::ST_IDLE;
      end
      default: state_d = nslr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      nslr_pkg::ST_IDLE: begin
        cur_q <= q_stat_i.item;
        e_q <= e_in;
        m_q <= m_in;
        frac_q <= 24'd0;
        iter_q <= 5'd0;
      end
      nslr_pkg::ST_LOG: begin
        m_q <= m_nx;
        frac_q <= {frac_q[22:0], msq[31]};
        iter_q <= iter_q + 5'd1;
      end
      nslr_pkg::ST_MUL: prod_q <= 64'(d) * 64'(nslr_pkg::Ln2Q32);
      nslr_pkg::ST_RND: r_q <= prod_rnd[63:32];
      nslr_pkg::ST_SQ: sq_q <= 64'(r_q) * 64'(r_q);
      nslr_pkg::ST_UPD: begin
        prev_p_q <= cur_q.price;
        prev_log_q <= cur_log;
        res_cnt_q <= cnt_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_ok_q <= 1'b0;
      sum_q <= 64'd0;
      cnt_q <= 16'd0;
      out_vld_q <= 1'b0;
    end else begin
      if (state_q == nslr_pkg::ST_ACC) begin
        sum_q <= sum_q + {16'd0, sq_rnd[63:16]};
        cnt_q <= cnt_q + 16'd1;
      end
      if (state_q == nslr_pkg::ST_UPD) begin
        prev_ok_q <= cur_q.ok && !cur_q.last;
        if (cur_q.last) begin
          sum_q <= 64'd0;
          cnt_q <= 16'd0;
        end
      end
      if (state_q == nslr_pkg::ST_OUT && out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == nslr_pkg::ST_OUT && out_load) begin
      if (res_cnt_q == 16'd0) begin
        out_q <= '0;
      end else begin
        out_q.semivariance <= div_quo;
        out_q.defined <= 1'b1;
        out_q.negative_count <= res_cnt_q;
      end
    end
  end

  nslr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (sum_q + {39'd0, cnt_q, 9'd0}),
    .den_i  ({cnt_q, 10'd0}),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  assign out_valid_o = out_vld_q;
  assign out_res_o = out_q;

  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NegCap) else $error("negative count above cap");
  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == nslr_pkg::ST_DIV) else $error("divider done outside wait");
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q) == nslr_pkg::ST_OUT) else $error("stray result");
  a_pop_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> state_q != nslr_pkg::ST_IDLE) else $error("pop without advance");

endmodule
